### rtl/core/ssu_pkg.sv
// Shared constants, codes and control structs for the substring search unit.
package ssu_pkg;

  // Pattern capacity and derived widths
  localparam int PAT_MAX   = 64;
  localparam int PAT_AW    = $clog2(PAT_MAX);
  localparam int LEN_W     = $clog2(PAT_MAX + 1);
  localparam int TXT_DEPTH = 1 << PAT_AW;   // ring of a power-of-two depth, >= PAT_MAX
  localparam int BYTE_W    = 8;
  localparam int KIND_W    = 2;
  localparam int POS_W     = 32;

  // Input beat kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_PAT   = 2'd1,
    KIND_TEXT  = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CK,
    ST_POS,
    ST_EMIT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic rd;         // read pattern and window bytes at the compare index
    logic inc;        // step compare index
    logic set_found;  // search ends with a match
    logic set_miss;   // search ends without a match
    logic pos;        // work out the end position
    logic load;       // move the result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic text_live;  // input beat is a text byte and the search is still open
    logic len_zero;   // pattern empty
    logic too_short;  // fewer text bytes seen than pattern bytes, this beat included
    logic in_last;    // tlast of the input beat
    logic last_r;     // tlast of the text beat under compare
    logic byte_eq;    // registered pattern and window bytes agree
    logic idx_end;    // compare index is on the last pattern byte
    logic out_busy;   // output register holds a beat not taken this cycle
    logic done;       // search finished, text ignored until clear
  } sts_t;

endpackage

### rtl/core/ssu_ctrl.sv
// Sequencer for the substring search: beat intake, byte compare loop and result hand-off.
module ssu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  ssu_pkg::sts_t sts,
  output ssu_pkg::cmd_t cmd
);
  import ssu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (sts.text_live) begin
            if (sts.len_zero) begin
              cmd.set_found = 1'b1;
              state_nxt     = ST_POS;
            end else if (sts.too_short) begin
              if (sts.in_last) begin
                cmd.set_miss = 1'b1;
                state_nxt    = ST_EMIT;
              end
            end else begin
              state_nxt = ST_RD;
            end
          end
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CK;
      end
      ST_CK: begin
        if (sts.byte_eq) begin
          if (sts.idx_end) begin
            cmd.set_found = 1'b1;
            state_nxt     = ST_POS;
          end else begin
            cmd.inc   = 1'b1;
            state_nxt = ST_RD;
          end
        end else if (sts.last_r) begin
          cmd.set_miss = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/ssu_dp.sv
// Datapath: pattern and text memories, counters, compare and position arithmetic, output register.
module ssu_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ssu_pkg::POS_W-1:0]     cfg_wr_data,
  input  logic [ssu_pkg::BYTE_W-1:0]    in_tdata,
  input  logic [ssu_pkg::KIND_W-1:0]    in_tuser,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [2*ssu_pkg::POS_W-1:0]   out_tdata,
  output logic                          out_tuser,
  input  ssu_pkg::cmd_t                 cmd,
  output ssu_pkg::sts_t                 sts
);
  import ssu_pkg::*;

  logic [BYTE_W-1:0] pat_mem [PAT_MAX];
  logic [BYTE_W-1:0] txt_mem [TXT_DEPTH];

  logic [POS_W-1:0]  ws_r;
  logic [LEN_W-1:0]  len_r;
  logic [POS_W-1:0]  bs_r;
  logic              done_r;
  logic [PAT_AW-1:0] wptr_r;
  logic [PAT_AW-1:0] idx_r;
  logic              last_r;
  logic              found_r;
  logic [BYTE_W-1:0] pat_q_r;
  logic [BYTE_W-1:0] txt_q_r;
  logic [POS_W-1:0]  end_pos_r;
  logic              out_tvalid_r;
  logic              out_found_r;
  logic [POS_W-1:0]  out_first_r;
  logic [POS_W-1:0]  out_last_r;

  logic [POS_W-1:0]  bs_inc;
  logic              is_clear;
  logic              is_pat;
  logic              is_text;
  logic              pat_wr;
  logic              txt_wr;
  logic [PAT_AW:0]   txt_ra_full;
  logic [PAT_AW-1:0] txt_ra;
  logic [LEN_W-1:0]  idx_next;
  logic [POS_W-1:0]  len_ext;
  logic [POS_W-1:0]  first_pos;

  // Beat decode
  assign is_clear = (in_tuser == KIND_CLEAR);
  assign is_pat   = (in_tuser == KIND_PAT);
  assign is_text  = (in_tuser == KIND_TEXT);
  assign pat_wr   = cmd.accept && is_pat && (len_r < LEN_W'(PAT_MAX));
  assign txt_wr   = cmd.accept && is_text && !done_r;

  // Saturating count of text bytes
  assign bs_inc = (bs_r == {POS_W{1'b1}}) ? bs_r : bs_r + POS_W'(1);

  // Window read address: oldest byte of the last len bytes, plus compare index
  assign txt_ra_full = {1'b0, wptr_r} - (PAT_AW+1)'(len_r) + {1'b0, idx_r};
  assign txt_ra      = txt_ra_full[PAT_AW-1:0];
  assign idx_next    = LEN_W'(idx_r) + LEN_W'(1);
  assign len_ext     = POS_W'(len_r);

  // Status
  always_comb begin
    sts           = '0;
    sts.text_live = is_text && !done_r;
    sts.len_zero  = (len_r == '0);
    sts.too_short = (bs_inc < len_ext);
    sts.in_last   = in_tlast;
    sts.last_r    = last_r;
    sts.byte_eq   = (pat_q_r == txt_q_r);
    sts.idx_end   = (idx_next == len_r);
    sts.out_busy  = out_tvalid_r && !out_tready;
    sts.done      = done_r;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= POS_W'(1);
    end else if (cfg_wr_en) begin
      ws_r <= cfg_wr_data;
    end
  end

  // Search control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      bs_r   <= '0;
      done_r <= 1'b0;
      wptr_r <= '0;
      idx_r  <= '0;
    end else begin
      if (cmd.accept && is_clear) begin
        len_r  <= '0;
        bs_r   <= '0;
        done_r <= 1'b0;
        wptr_r <= '0;
      end
      if (pat_wr) begin
        len_r <= len_r + LEN_W'(1);
      end
      if (txt_wr) begin
        wptr_r <= wptr_r + PAT_AW'(1);
        bs_r   <= bs_inc;
        idx_r  <= '0;
      end
      if (cmd.inc) begin
        idx_r <= idx_r + PAT_AW'(1);
      end
      if (cmd.set_found || cmd.set_miss) begin
        done_r <= 1'b1;
      end
    end
  end

  // Pattern memory
  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_mem[len_r[PAT_AW-1:0]] <= in_tdata;
    end
    if (cmd.rd) begin
      pat_q_r <= pat_mem[idx_r];
    end
  end

  // Text window ring
  always_ff @(posedge clk) begin
    if (txt_wr) begin
      txt_mem[wptr_r] <= in_tdata;
    end
    if (cmd.rd) begin
      txt_q_r <= txt_mem[txt_ra];
    end
  end

  // Per-search payload: tlast of the beat, outcome and end position
  always_ff @(posedge clk) begin
    if (txt_wr) begin
      last_r <= in_tlast;
    end
    if (cmd.set_found || cmd.set_miss) begin
      found_r <= cmd.set_found;
    end
    if (cmd.pos) begin
      end_pos_r <= (len_r == '0) ? ws_r - POS_W'(1) : ws_r + bs_r - POS_W'(1);
    end
  end

  // Start position from end position; empty pattern starts at the window start
  assign first_pos = (len_r == '0) ? ws_r : end_pos_r - (len_ext - POS_W'(1));

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_found_r <= found_r;
      out_first_r <= found_r ? first_pos : '0;
      out_last_r  <= found_r ? end_pos_r : '0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {out_last_r, out_first_r};

endmodule

### rtl/core/substring_search_unit.sv
// Top level of the substring search unit: sequencer, datapath and checks.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tdata: data_byte; tuser: kind; tlast: last
//  out_     out  out_tvalid/out_tready  tdata: first_pos, last_pos; tuser: found
//  cfg_     in   cfg_wr_en              cfg_wr_data: window_start
//
// Clear and pattern beats are taken in the idle state. A text beat is taken there too,
// then each pattern byte is compared in a read and a check state up to the first
// mismatch; a found result passes the position and emit states, a not-found result
// only the emit state, waiting while the output register still holds a beat. The
// compare loop reads one pattern and one window byte per pass from single-port memories.
// Reset is synchronous, active low; no clearing pass is needed.
// A result waits in the output register; a further result stalls until that beat is taken.
module substring_search_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ssu_pkg::POS_W-1:0]     cfg_wr_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ssu_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic [ssu_pkg::KIND_W-1:0]    in_tuser,   // [1:0] kind
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [2*ssu_pkg::POS_W-1:0]   out_tdata,  // [31:0] first_pos, [63:32] last_pos
  output logic                          out_tuser   // [0] found
);
  import ssu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ssu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssu_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cmd         (cmd),
    .sts         (sts)
  );

`ifndef NO_ASSERTIONS
  // A not-found beat carries zero positions
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("not-found result with non-zero positions");

  // Every result beat closes the search
  a_result_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> sts.done)
    else $error("result issued while search still open");

  // A clear beat reopens the search
  a_clear_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == KIND_CLEAR)) |=> !sts.done)
    else $error("search still closed after clear");
`endif

endmodule
